>>> src/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants of the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int unsigned Dim      = 4;
  localparam int unsigned ElemW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumElem  = Dim * Dim;
  localparam int unsigned IdxW     = $clog2(NumElem);
  localparam int unsigned KW       = $clog2(Dim);
  localparam int unsigned StepW    = IdxW + KW;
  localparam int unsigned ProdW    = 2 * ElemW;
  localparam int unsigned AccW     = ProdW + KW;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef struct packed {
    logic signed [ElemW-1:0] left_element;
    logic signed [ElemW-1:0] right_element;
  } in_item_t;

  typedef struct packed {
    logic signed [ElemW-1:0] product_element;
    logic [IdxW-1:0]         element_index;
    logic                    is_last;
  } out_item_t;

  typedef struct packed {
    in_item_t        data;
    logic [IdxW-1:0] idx;
    logic            last;
  } q_item_t;

endpackage

>>> src/mm4_fifo.sv
// ----------------------------------------------------------------------------
// mm4_fifo
// Short queue between the loading front end and the compute back end.
// ----------------------------------------------------------------------------
module mm4_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mm4_pkg::q_item_t push_item_i,
  output logic             full_o,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output mm4_pkg::q_item_t pop_item_o
);
  import mm4_pkg::*;

  q_item_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == QCntW'(QDepth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_item_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> src/mm4_front.sv
// ----------------------------------------------------------------------------
// mm4_front
// Accepts input items and tags each with its matrix position.
// ----------------------------------------------------------------------------
module mm4_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mm4_pkg::in_item_t in_item_i,
  output logic              push_o,
  output mm4_pkg::q_item_t  push_item_o,
  input  logic              full_i
);
  import mm4_pkg::*;

  logic [IdxW-1:0] count_q, count_d;

  assign in_stall_o         = full_i;
  assign push_o             = in_valid_i && !full_i;
  assign push_item_o.data   = in_item_i;
  assign push_item_o.idx    = count_q;
  assign push_item_o.last   = (count_q == IdxW'(NumElem - 1));
  assign count_d            = push_o ? count_q + 1'b1 : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

>>> src/mm4_back.sv
// ----------------------------------------------------------------------------
// mm4_back
// Stores both matrices and runs the shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module mm4_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  mm4_pkg::q_item_t   pop_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mm4_pkg::out_item_t out_item_o
);
  import mm4_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_CALC = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [StepW-1:0]        step_q, step_d;
  logic signed [ElemW-1:0] left_mem [NumElem];
  logic signed [ElemW-1:0] right_mem [NumElem];
  logic signed [ElemW-1:0] a_q, b_q;
  logic                    rd_vld_q;
  logic [StepW-1:0]        rd_step_q;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic                    pr_vld_q;
  logic [StepW-1:0]        pr_step_q;
  logic signed [AccW-1:0]  acc_q, sum_d, shifted;
  logic [AccW-ElemW:0]     upper;
  logic signed [ElemW-1:0] sat_d;
  logic                    en, issue, finish;
  logic [KW-1:0]           pr_k;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q;

  assign en     = !(out_valid_q && out_stall_i);
  assign pop_o  = (state_q == ST_LOAD) && pop_valid_i;
  assign issue  = (state_q == ST_CALC) && en;
  assign pr_k   = pr_step_q[KW-1:0];
  assign finish = en && pr_vld_q && (pr_k == KW'(Dim - 1));

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_LOAD: begin
        if (pop_o && pop_item_i.last) begin
          state_d = ST_CALC;
          step_d  = '0;
        end
      end
      ST_CALC: begin
        if (issue) begin
          step_d = step_q + 1'b1;
          if (step_q == StepW'(NumElem * Dim - 1)) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      left_mem[pop_item_i.idx]  <= pop_item_i.data.left_element;
      right_mem[pop_item_i.idx] <= pop_item_i.data.right_element;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q       <= left_mem[{step_q[KW-1:0], step_q[2*KW-1:KW]}];
      b_q       <= right_mem[{step_q[StepW-1:2*KW], step_q[KW-1:0]}];
      rd_step_q <= step_q;
      prod_q    <= prod_d;
      pr_step_q <= rd_step_q;
    end
    if (en && pr_vld_q) begin
      acc_q <= sum_d;
    end
  end

  assign prod_d  = a_q * b_q;
  assign sum_d   = ((pr_k == '0) ? AccW'(0) : acc_q) + AccW'(prod_q);
  assign shifted = sum_d >>> FracBits;
  assign upper   = shifted[AccW-1:ElemW-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      sat_d = shifted[ElemW-1:0];
    end else if (shifted[AccW-1]) begin
      sat_d = {1'b1, {(ElemW-1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(ElemW-1){1'b1}}};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q.product_element <= sat_d;
      out_q.element_index   <= pr_step_q[StepW-1:KW];
      out_q.is_last         <= (pr_step_q[StepW-1:KW] == IdxW'(NumElem - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      step_q      <= '0;
      rd_vld_q    <= 1'b0;
      pr_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (en) begin
        rd_vld_q <= issue;
        pr_vld_q <= rd_vld_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> src/matrix4x4_multiply.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Product of two column-major 4x4 matrices in signed Q16.16, saturated.
// ----------------------------------------------------------------------------
// Each input item carries one left and one right element in column-major
// order. Items pass through a two-entry queue into the matrix stores. The
// stores are written only while no product is being formed, so during a
// product the input side takes at most two items before it stalls. After the
// sixteenth item leaves the queue, one shared 32x32 multiplier with a wide
// accumulator forms the product, four multiply-accumulates per element. The
// 16 result items leave in element order; each is formed from the operand
// registers, the product register and the accumulator and is held in the
// output register. A stalled output freezes the multiply pipeline until the
// waiting result item is taken.
module matrix4x4_multiply (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mm4_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mm4_pkg::out_item_t out_item_o
);
  import mm4_pkg::*;

  logic    push, full, pop_valid, pop;
  q_item_t push_item, pop_item;

  mm4_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  mm4_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_item_o  (pop_item)
  );

  mm4_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
